// File: rtl/dlrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlrd_pkg - shared types and constants of the dual LC rotation detector
// Transaction structs, register indexes, reset values and history event codes.
// ----------------------------------------------------------------------------
package dlrd_pkg;

  // Input transaction: one scan of both sensor channels
  typedef struct packed {
    logic [7:0] count_a;
    logic       valid_a;
    logic [7:0] count_b;
    logic       valid_b;
  } in_item_t;

  // Result transaction: one per scan
  typedef struct packed {
    logic        forward_rev;
    logic        reverse_rev;
    logic [31:0] reverse_total;
    logic        attack_detected;
  } out_item_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FILTER_DELTA = 2'd0,
    REG_ATTACK_LEVEL = 2'd1,
    REG_ATTACK_LIMIT = 2'd2,
    REG_ATTACK_TRIP  = 2'd3
  } cfg_reg_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // Register reset values
  localparam logic [7:0] FilterDeltaRst = 8'd3;
  localparam logic [7:0] AttackLevelRst = 8'd40;
  localparam logic [7:0] AttackLimitRst = 8'd60;
  localparam logic [7:0] AttackTripRst  = 8'd30;

  // Extremum seen by a channel history on one shift
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_PEAK   = 2'd1,
    EV_VALLEY = 2'd2
  } hist_evt_e;

  // Attack tracker status handed to the rest of the step
  typedef struct packed {
    logic       stop;    // attack step: histories and marks stay untouched
    logic       flag;    // sticky attack flag after this scan
    logic [7:0] held_a;  // channel A count after this scan
    logic [7:0] held_b;  // channel B count after this scan
  } atk_status_t;

endpackage
`default_nettype wire

// File: rtl/dlrd_attack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlrd_attack - held counts and magnetic attack tracker
// Keeps the last valid count of each channel, runs the attack up/down
// counter and the sticky attack flag.
// ----------------------------------------------------------------------------
module dlrd_attack (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire dlrd_pkg::in_item_t   item_i,
  input  wire logic [7:0]           attack_level_i,
  input  wire logic [7:0]           attack_limit_i,
  input  wire logic [7:0]           attack_trip_i,
  output dlrd_pkg::atk_status_t     status_o
);

  logic [7:0] held_a_q, held_a_d;
  logic [7:0] held_b_q, held_b_d;
  logic [7:0] cnt_q, cnt_d;
  logic       flag_q, flag_d;
  logic       inc;
  logic       stop;

  // Hold the last count of a channel that produced nothing this scan
  assign held_a_d = item_i.valid_a ? item_i.count_a : held_a_q;
  assign held_b_d = item_i.valid_b ? item_i.count_b : held_b_q;

  // Count up while both counts sit under the level and the counter is under the limit, else count down to zero
  assign inc = (held_a_d < attack_level_i) && (held_b_d < attack_level_i) &&
               (cnt_q < attack_limit_i);

  always_comb begin
    if (inc) begin
      cnt_d = cnt_q + 8'd1;
    end else if (cnt_q != 8'd0) begin
      cnt_d = cnt_q - 8'd1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign stop   = (cnt_d >= attack_trip_i);
  assign flag_d = flag_q | stop;

  // Advance on every accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_a_q <= '0;
      held_b_q <= '0;
      cnt_q    <= '0;
      flag_q   <= 1'b0;
    end else if (step_i) begin
      held_a_q <= held_a_d;
      held_b_q <= held_b_d;
      cnt_q    <= cnt_d;
      flag_q   <= flag_d;
    end
  end

  assign status_o.stop   = stop;
  assign status_o.flag   = flag_d;
  assign status_o.held_a = held_a_d;
  assign status_o.held_b = held_b_d;

endmodule
`default_nettype wire

// File: rtl/dlrd_history.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlrd_history - three-deep count history of one channel
// Seeds an empty history, shifts in a count that moved by at least the filter delta and reports
// whether the middle entry became a peak or a valley.
// ----------------------------------------------------------------------------
module dlrd_history (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [7:0]           sample_i,
  input  wire logic [7:0]           filter_delta_i,
  output dlrd_pkg::hist_evt_e       evt_o
);

  // Index 2 is the newest entry
  logic [7:0] h0_q, h1_q, h2_q;
  logic [7:0] diff;
  logic       empty;
  logic       shift;

  assign empty = (h2_q == 8'd0);
  assign diff  = (sample_i >= h2_q) ? (sample_i - h2_q) : (h2_q - sample_i);
  assign shift = !empty && (diff >= filter_delta_i);

  // Classify the entry that moves to the middle; skip while the middle entry is empty
  always_comb begin
    evt_o = dlrd_pkg::EV_NONE;
    if (shift && (h1_q != 8'd0)) begin
      if ((h2_q > h1_q) && (h2_q > sample_i)) begin
        evt_o = dlrd_pkg::EV_PEAK;
      end else if ((h2_q < h1_q) && (h2_q < sample_i)) begin
        evt_o = dlrd_pkg::EV_VALLEY;
      end
    end
  end

  // Seed an empty history, otherwise shift on a large enough move
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_q <= '0;
      h1_q <= '0;
      h2_q <= '0;
    end else if (step_i) begin
      if (empty) begin
        h2_q <= sample_i;
      end else if (shift) begin
        h0_q <= h1_q;
        h1_q <= h2_q;
        h2_q <= sample_i;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/dual_lc_rotation_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_lc_rotation_detector_unit - rotation and attack detector, two LC channels
// Tracks peaks and valleys of both channels, reports forward and reverse
// revolutions and a sticky magnetic attack flag, one result per scan.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       sink       in_valid_i / in_ready_o  in_data_i  (dlrd_pkg::in_item_t)
//  out      source     out_valid_o / out_ready_i out_data_o (dlrd_pkg::out_item_t)
//  cfg      sink       cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
//  One transaction per cycle unless out stalls; result valid in the next cycle.
//  The state update is a single combinational pass from the accepted scan
//  into the state registers and the result register.
//  The input is ready whenever the result register is empty or being taken.
//  Reset clears all state but out_q, loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module dual_lc_rotation_detector_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire dlrd_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output dlrd_pkg::out_item_t                  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [dlrd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [dlrd_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam logic [3:0] MarkAPeak   = 4'b0001;
  localparam logic [3:0] MarkAValley = 4'b0010;
  localparam logic [3:0] MarkBPeak   = 4'b0100;
  localparam logic [3:0] MarkBValley = 4'b1000;

  logic [7:0] filter_delta_q, attack_level_q, attack_limit_q, attack_trip_q;

  logic                  accept;
  logic                  hist_step;
  dlrd_pkg::atk_status_t atk;
  dlrd_pkg::hist_evt_e   evt_a, evt_b;

  logic [3:0]  marks_q, marks_d;
  logic        a_ready_q, a_ready_d;
  logic        dir_fwd_q, dir_fwd_d;
  logic [31:0] rev_cnt_q, rev_cnt_d;
  logic        fwd, rev;

  logic                out_valid_q;
  dlrd_pkg::out_item_t out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hist_step  = accept && !atk.stop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_delta_q <= dlrd_pkg::FilterDeltaRst;
      attack_level_q <= dlrd_pkg::AttackLevelRst;
      attack_limit_q <= dlrd_pkg::AttackLimitRst;
      attack_trip_q  <= dlrd_pkg::AttackTripRst;
    end else if (cfg_we_i) begin
      case (dlrd_pkg::cfg_reg_e'(cfg_idx_i))
        dlrd_pkg::REG_FILTER_DELTA: filter_delta_q <= cfg_wdata_i;
        dlrd_pkg::REG_ATTACK_LEVEL: attack_level_q <= cfg_wdata_i;
        dlrd_pkg::REG_ATTACK_LIMIT: attack_limit_q <= cfg_wdata_i;
        dlrd_pkg::REG_ATTACK_TRIP:  attack_trip_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dlrd_attack u_attack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (accept),
    .item_i         (in_data_i),
    .attack_level_i (attack_level_q),
    .attack_limit_i (attack_limit_q),
    .attack_trip_i  (attack_trip_q),
    .status_o       (atk)
  );

  dlrd_history u_hist_a (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (hist_step),
    .sample_i       (atk.held_a),
    .filter_delta_i (filter_delta_q),
    .evt_o          (evt_a)
  );

  dlrd_history u_hist_b (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (hist_step),
    .sample_i       (atk.held_b),
    .filter_delta_i (filter_delta_q),
    .evt_o          (evt_b)
  );

  // Update point marks and direction, emit a revolution once all four are seen
  always_comb begin
    marks_d   = marks_q;
    a_ready_d = a_ready_q;
    dir_fwd_d = dir_fwd_q;
    rev_cnt_d = rev_cnt_q;
    fwd       = 1'b0;
    rev       = 1'b0;
    if (!atk.stop) begin
      case (evt_a)
        dlrd_pkg::EV_PEAK: begin
          marks_d   = (marks_d | MarkAPeak) & ~MarkAValley;
          a_ready_d = 1'b1;
        end
        dlrd_pkg::EV_VALLEY: begin
          marks_d   = marks_d | MarkAValley;
          a_ready_d = 1'b0;
        end
        default: ;
      endcase
      case (evt_b)
        dlrd_pkg::EV_PEAK: begin
          marks_d   = (marks_d | MarkBPeak) & ~MarkBValley;
          dir_fwd_d = !a_ready_d;
        end
        dlrd_pkg::EV_VALLEY: begin
          marks_d = marks_d | MarkBValley;
        end
        default: ;
      endcase
      if (&marks_d) begin
        if (dir_fwd_d) begin
          fwd = 1'b1;
        end else begin
          rev       = 1'b1;
          rev_cnt_d = rev_cnt_q + 32'd1;
        end
        marks_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q   <= '0;
      a_ready_q <= 1'b0;
      dir_fwd_q <= 1'b1;
      rev_cnt_q <= '0;
    end else if (accept) begin
      marks_q   <= marks_d;
      a_ready_q <= a_ready_d;
      dir_fwd_q <= dir_fwd_d;
      rev_cnt_q <= rev_cnt_d;
    end
  end

  // Result register: load on accept, drop when taken
  always_comb begin
    out_d.forward_rev     = fwd;
    out_d.reverse_rev     = rev;
    out_d.reverse_total   = rev_cnt_d;
    out_d.attack_detected = atk.flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An attack step never reports a revolution
  a_attack_no_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && atk.stop) |=> (!out_q.forward_rev && !out_q.reverse_rev))
    else $error("revolution reported on an attack step");

  // The attack flag never falls from one result to the next
  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_valid_q && out_q.attack_detected) |=> out_q.attack_detected)
    else $error("attack flag cleared");

  // The reverse total moves only with a reverse revolution
  a_rev_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !rev) |=> (rev_cnt_q == $past(rev_cnt_q)))
    else $error("reverse total changed without a reverse revolution");

  // Marks are cleared whenever a revolution is reported
  a_marks_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (fwd || rev)) |=> (marks_q == 4'd0))
    else $error("point marks not cleared after a revolution");

endmodule
`default_nettype wire
